// ===== hdl/mcr_pkg.sv =====
package mcr_pkg;

  // Point coordinates are 14-bit two's complement and wrap.
  localparam int PT_BITS = 14;
  localparam int OUT_DATA_BITS = ((2 * PT_BITS + 7) / 8) * 8;

  localparam int RADIUS_BITS_DEFAULT = 10;
  localparam int COORD_BITS_DEFAULT = 12;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CONTINUE = 1'b1;

  localparam logic [2:0] LAST_POINT = 3'd7;

endpackage

// ===== hdl/mcr_queue.sv =====
module mcr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/mcr_front.sv =====
module mcr_front #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS = 12,
  parameter int IN_DATA_BITS = 40,
  parameter int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DATA_BITS-1:0] s_tdata,   // center_x, center_y, radius
  input  logic                    s_tuser,   // cmd
  output logic                    job_valid,
  input  logic                    job_ready,
  output logic [JOB_BITS-1:0]     job_data   // cx, cy, offset_major, offset_minor, done
);
  import mcr_pkg::*;

  localparam int EW = RADIUS_BITS + 4;
  localparam int SW = RADIUS_BITS + 2;
  localparam int DW = RADIUS_BITS + 1;

  logic                   active;
  logic [COORD_BITS-1:0]  cur_cx;
  logic [COORD_BITS-1:0]  cur_cy;
  logic [DW-1:0]          diameter;
  logic signed [DW-1:0]   off_major;
  logic [RADIUS_BITS-1:0] off_minor;
  logic [SW-1:0]          step_major;
  logic [SW-1:0]          step_minor;
  logic signed [EW-1:0]   err;

  logic [COORD_BITS-1:0]  in_cx;
  logic [COORD_BITS-1:0]  in_cy;
  logic [RADIUS_BITS-1:0] in_r;
  logic                   start;
  logic                   accept;

  logic                   b_active;
  logic [COORD_BITS-1:0]  b_cx;
  logic [COORD_BITS-1:0]  b_cy;
  logic [DW-1:0]          b_diam;
  logic signed [DW-1:0]   b_major;
  logic [RADIUS_BITS-1:0] b_minor;
  logic [SW-1:0]          b_smaj;
  logic [SW-1:0]          b_smin;
  logic signed [EW-1:0]   b_err;

  logic [RADIUS_BITS-1:0] minor_next;
  logic [SW-1:0]          smin_next;
  logic signed [EW-1:0]   err_mid;
  logic signed [DW-1:0]   major_next;
  logic [SW-1:0]          smaj_next;
  logic signed [EW-1:0]   err_next;
  logic                   done;

  assign in_cx  = s_tdata[COORD_BITS-1:0];
  assign in_cy  = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_r   = s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign start  = (s_tuser == CMD_START);
  assign accept = s_tvalid && s_tready;

  // Starting values: a start reloads, a continue carries the stored circle.
  always_comb begin
    if (start) begin
      b_cx     = in_cx;
      b_cy     = in_cy;
      b_diam   = {in_r, 1'b0};
      b_major  = $signed({1'b0, in_r}) - DW'(1);
      b_minor  = '0;
      b_smaj   = SW'(1);
      b_smin   = SW'(1);
      b_err    = EW'(1) - $signed({3'b000, in_r, 1'b0});
      b_active = (in_r != '0);
    end else begin
      b_cx     = cur_cx;
      b_cy     = cur_cy;
      b_diam   = diameter;
      b_major  = off_major;
      b_minor  = off_minor;
      b_smaj   = step_major;
      b_smin   = step_minor;
      b_err    = err;
      b_active = active;
    end
  end

  // One midpoint iteration: row step, then column step.
  always_comb begin
    if (b_err <= 0) begin
      minor_next = b_minor + RADIUS_BITS'(1);
      err_mid    = b_err + $signed({2'b00, b_smin});
      smin_next  = b_smin + SW'(2);
    end else begin
      minor_next = b_minor;
      err_mid    = b_err;
      smin_next  = b_smin;
    end
    if (err_mid > 0) begin
      major_next = b_major - DW'(1);
      smaj_next  = b_smaj + SW'(2);
      err_next   = err_mid + $signed({2'b00, smaj_next}) - $signed({3'b000, b_diam});
    end else begin
      major_next = b_major;
      smaj_next  = b_smaj;
      err_next   = err_mid;
    end
    done = (major_next < $signed({1'b0, minor_next}));
  end

  assign s_tready  = job_ready;
  assign job_valid = s_tvalid && b_active;
  assign job_data  = {done, b_minor, b_major, b_cy, b_cx};

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      cur_cx     <= '0;
      cur_cy     <= '0;
      diameter   <= '0;
      off_major  <= '0;
      off_minor  <= '0;
      step_major <= SW'(1);
      step_minor <= SW'(1);
      err        <= '0;
    end else if (accept) begin
      cur_cx   <= b_cx;
      cur_cy   <= b_cy;
      diameter <= b_diam;
      if (b_active) begin
        active     <= !done;
        off_major  <= major_next;
        off_minor  <= minor_next;
        step_major <= smaj_next;
        step_minor <= smin_next;
        err        <= err_next;
      end else begin
        active     <= 1'b0;
        off_major  <= b_major;
        off_minor  <= b_minor;
        step_major <= b_smaj;
        step_minor <= b_smin;
        err        <= b_err;
      end
    end
  end

endmodule

// ===== hdl/mcr_back.sv =====
module mcr_back #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS = 12,
  parameter int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  logic [JOB_BITS-1:0]                 job_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mcr_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // point_x, point_y, zero fill
  output logic                                m_tlast,  // last_of_step
  output logic                                m_tuser   // circle_done
);
  import mcr_pkg::*;

  localparam int DW = RADIUS_BITS + 1;
  localparam int MAXW = (COORD_BITS > DW) ? COORD_BITS : DW;
  localparam int WW = ((MAXW > PT_BITS) ? MAXW : PT_BITS) + 1;

  logic                   busy;
  logic [2:0]             idx;
  logic [COORD_BITS-1:0]  cx;
  logic [COORD_BITS-1:0]  cy;
  logic signed [DW-1:0]   major;
  logic [RADIUS_BITS-1:0] minor;
  logic                   done;

  logic                   emit;
  logic                   load;
  logic signed [WW-1:0]   major_w;
  logic signed [WW-1:0]   minor_w;
  logic signed [WW-1:0]   off_x;
  logic signed [WW-1:0]   off_y;
  logic signed [WW-1:0]   px;
  logic signed [WW-1:0]   py;

  assign emit      = busy && (!m_tvalid || m_tready);
  assign load      = !busy || (emit && (idx == LAST_POINT));
  assign job_ready = load;

  assign major_w = WW'(major);
  assign minor_w = $signed(WW'(minor));

  // Octant mirror: upper half swaps offsets, bit 1 negates x, bit 0 clear negates y.
  always_comb begin
    off_x = idx[2] ? minor_w : major_w;
    off_y = idx[2] ? major_w : minor_w;
    px    = idx[1] ? ($signed(WW'(cx)) - off_x) : ($signed(WW'(cx)) + off_x);
    py    = idx[0] ? ($signed(WW'(cy)) + off_y) : ($signed(WW'(cy)) - off_y);
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      {done, minor, major, cy, cx} <= job_data;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= OUT_DATA_BITS'({py[PT_BITS-1:0], px[PT_BITS-1:0]});
      m_tlast <= (idx == LAST_POINT);
      m_tuser <= (idx == LAST_POINT) && done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        idx      <= idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        busy <= job_valid;
        idx  <= '0;
      end
    end
  end

endmodule

// ===== hdl/midpoint_circle_rasterizer_top.sv =====
// channel  dir  tdata (low bit up)                        tuser         tlast
// s_*      in   center_x, center_y, radius, zero fill    cmd           -
// m_*      out  point_x, point_y, zero fill              circle_done   last_of_step
//
// Each accepted item yields eight points or none; the point serializer
// emits one point a cycle while the sink is ready.
// The iteration unit feeds a two-entry job queue, so inputs keep flowing
// while the serializer or the sink stalls, until the queue fills.
// An item's first point passes the queue, the job registers and the output register.
// Synchronous active-high reset clears circle state, queue and output valid.
module midpoint_circle_rasterizer_top #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEFAULT,
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT,
  parameter int IN_DATA_BITS = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_DATA_BITS-1:0]           s_tdata,   // center_x, center_y, radius, zero fill
  input  logic                              s_tuser,   // cmd
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mcr_pkg::OUT_DATA_BITS-1:0] m_tdata,   // point_x, point_y, zero fill
  output logic                              m_tlast,   // last_of_step
  output logic                              m_tuser    // circle_done
);

  localparam int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 2;

  logic                push_valid;
  logic                push_ready;
  logic [JOB_BITS-1:0] push_data;
  logic                pop_valid;
  logic                pop_ready;
  logic [JOB_BITS-1:0] pop_data;

  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .IN_DATA_BITS(IN_DATA_BITS),
    .JOB_BITS    (JOB_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .job_valid(push_valid),
    .job_ready(push_ready),
    .job_data (push_data)
  );

  mcr_queue #(
    .WIDTH(JOB_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push_valid),
    .in_ready (push_ready),
    .in_data  (push_data),
    .out_valid(pop_valid),
    .out_ready(pop_ready),
    .out_data (pop_data)
  );

  mcr_back #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS),
    .JOB_BITS   (JOB_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(pop_valid),
    .job_ready(pop_ready),
    .job_data (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  a_done_on_last: assert property (@(posedge clk) m_tvalid && m_tuser |-> m_tlast)
    else $error("circle_done without last_of_step");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_queue_gates_input: assert property (@(posedge clk)
    disable iff (rst) !push_ready |-> !s_tready)
    else $error("input taken while job queue full");

endmodule

// ===== bench/midpoint_circle_rasterizer_top_tb.sv =====
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_top_tb;
  import mcr_pkg::*;

  localparam int IN_BITS = ((2 * COORD_BITS_DEFAULT + RADIUS_BITS_DEFAULT + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 70;
  localparam int CALM_FROM = 55;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [PT_BITS-1:0] px;
    logic [PT_BITS-1:0] py;
    logic               last;
    logic               done;
  } outline_point_t;

  class point_scoreboard;
    outline_point_t pending_points[$];
    int mismatches;
    int points_checked;
    int starts;
    int continues;
    int idle_continues;
    int circles_completed;
    bit busy;
    logic [COORD_BITS_DEFAULT-1:0] ctr_x;
    logic [COORD_BITS_DEFAULT-1:0] ctr_y;
    int diameter;
    int major;
    int minor;
    int major_step;
    int minor_step;
    int err;

    function new();
      busy = 0;
      ctr_x = '0;
      ctr_y = '0;
      diameter = 0;
      major = 0;
      minor = 0;
      major_step = 1;
      minor_step = 1;
      err = 0;
    endfunction

    function logic [PT_BITS-1:0] wrap_coord(logic [COORD_BITS_DEFAULT-1:0] c, int off,
                                            bit neg);
      int v;
      v = neg ? int'(c) - off : int'(c) + off;
      return v[PT_BITS-1:0];
    endfunction

    function void report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Run one midpoint iteration on an accepted transaction and queue its eight points, if the circle is active.
    function void note_item(logic cmd, logic [COORD_BITS_DEFAULT-1:0] cx,
                            logic [COORD_BITS_DEFAULT-1:0] cy,
                            logic [RADIUS_BITS_DEFAULT-1:0] r);
      int ox;
      int oy;
      bit fin;
      bit xneg;
      bit yneg;
      outline_point_t p;
      if (cmd == CMD_START) begin
        starts++;
        ctr_x = cx;
        ctr_y = cy;
        diameter = 2 * int'(r);
        major = int'(r) - 1;
        minor = 0;
        major_step = 1;
        minor_step = 1;
        err = 1 - diameter;
        busy = (major >= minor);
      end else begin
        continues++;
        if (!busy) idle_continues++;
      end
      if (!busy) return;

      ox = major;
      oy = minor;
      if (err <= 0) begin
        minor += 1;
        err += minor_step;
        minor_step += 2;
      end
      if (err > 0) begin
        major -= 1;
        major_step += 2;
        err += major_step - diameter;
      end
      fin = !(major >= minor);
      if (fin) begin
        busy = 0;
        circles_completed++;
      end

      // First four points swing the major offset along x, the last four along y.
      for (int k = 0; k < 8; k++) begin
        xneg = (k < 4) ? (k >= 2) : (k >= 6);
        yneg = (k % 2 == 0);
        p.px = wrap_coord(ctr_x, (k < 4) ? ox : oy, xneg);
        p.py = wrap_coord(ctr_y, (k < 4) ? oy : ox, yneg);
        p.last = (k == int'(LAST_POINT));
        p.done = (k == int'(LAST_POINT)) && fin;
        pending_points.push_back(p);
      end
    endfunction

    function void check_point(logic [PT_BITS-1:0] px, logic [PT_BITS-1:0] py,
                              logic last, logic done);
      outline_point_t e;
      points_checked++;
      if (pending_points.size() == 0) begin
        report($sformatf("point (%0d,%0d) with nothing pending", $signed(px), $signed(py)));
        return;
      end
      e = pending_points.pop_front();
      if (px !== e.px)
        report($sformatf("point_x got %0d want %0d", $signed(px), $signed(e.px)));
      if (py !== e.py)
        report($sformatf("point_y got %0d want %0d", $signed(py), $signed(e.py)));
      if (last !== e.last)
        report($sformatf("last_of_step got %b want %b", last, e.last));
      if (done !== e.done)
        report($sformatf("circle_done got %b want %b", done, e.done));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic s_tuser = CMD_START;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  bit calm = 0;
  bit hold_off = 0;
  int useful_items = 0;

  point_scoreboard sb = new();

  midpoint_circle_rasterizer_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_item(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[33:24]);
      if (m_tvalid && m_tready)
        sb.check_point(m_tdata[PT_BITS-1:0], m_tdata[2*PT_BITS-1:PT_BITS], m_tlast, m_tuser);
    end
  end

  // Sink: random stall bursts, plus one long hold-off on request.
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off = 0;
        m_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [COORD_BITS_DEFAULT-1:0] cx,
                           input logic [COORD_BITS_DEFAULT-1:0] cy,
                           input logic [RADIUS_BITS_DEFAULT-1:0] r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    if (!(cmd == CMD_CONTINUE && !sb.busy)) useful_items++;
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = IN_BITS'({r, cy, cx});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_continue();
    send_item(CMD_CONTINUE, 12'($urandom), 12'($urandom), 10'($urandom));
  endtask

  // Start a circle and keep stepping it until it finishes or the cap runs out.
  task automatic trace_circle(input logic [COORD_BITS_DEFAULT-1:0] cx,
                              input logic [COORD_BITS_DEFAULT-1:0] cy,
                              input logic [RADIUS_BITS_DEFAULT-1:0] r, input int cap);
    int n;
    n = 0;
    send_item(CMD_START, cx, cy, r);
    while (sb.busy && n < cap) begin
      send_continue();
      n++;
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_points.size() != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    int cap;
    logic [RADIUS_BITS_DEFAULT-1:0] r;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: idle engine, zero radius, tiny radii with wrap at both ends.
    send_continue();
    send_item(CMD_START, 12'd100, 12'd200, 10'd0);
    send_continue();
    send_item(CMD_START, 12'd0, 12'd0, 10'd1);
    send_continue();
    trace_circle(12'd4095, 12'd4095, 10'd2, 10);
    send_continue();

    // Abandon a full-size circle for a small one.
    trace_circle(12'd2048, 12'd2048, 10'd1023, 3);
    trace_circle(12'h555, 12'haaa, 10'd3, 10);

    // Long sink stall while the source keeps pushing; then let everything drain.
    send_item(CMD_START, 12'd4095, 12'd0, 10'd1023);
    hold_off = 1;
    repeat (5) send_continue();
    s_tvalid = 1'b0;
    wait_drained();
    trace_circle(12'd0, 12'd4095, 10'd512, 2);

    // Random: mostly whole circles, some abandoned, some stray transactions.
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      calm = (useful_items >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 7) == 0) begin
          r = 10'($urandom_range(0, 1023));
          cap = $urandom_range(1, 4);
        end else begin
          r = 10'($urandom_range(1, 24));
          cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : 1000;
        end
        trace_circle(12'($urandom), 12'($urandom), r, cap);
      end else if (pick < 85) begin
        send_continue();
      end else begin
        send_item(CMD_START, 12'($urandom), 12'($urandom), 10'($urandom));
      end
    end

    s_tvalid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);

    $display("Ran %0d starts and %0d continues (%0d on an idle engine).",
             sb.starts, sb.continues, sb.idle_continues);
    $display("Checked %0d points across %0d completed outlines.",
             sb.points_checked, sb.circles_completed);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.pending_points.size() != 0)
        sb.report($sformatf("%0d points never arrived", sb.pending_points.size()));
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("Timed out with %0d points outstanding", sb.pending_points.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mcr_pkg.sv
hdl/mcr_queue.sv
hdl/mcr_front.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer_top.sv
bench/midpoint_circle_rasterizer_top_tb.sv
